/* design/assert_macros.svh */
// assertion helpers used by text_console_writer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked only out of reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked only out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/tcw_pkg.sv */
package tcw_pkg;

    // port field widths
    localparam int COMMAND_W = 2;
    localparam int CHAR_W    = 8;
    localparam int INDEX_W   = 11;
    localparam int LOC_W     = 11;
    localparam int CELL_W    = 16;
    localparam int ATTR_W    = 8;

    // character codes
    localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_LAST  = 8'h7F;

    localparam int TAB_STOP = 8;

    // attribute after reset and the blank cell that reset leaves everywhere
    localparam logic [ATTR_W-1:0] RESET_ATTR  = 8'h0F;
    localparam logic [CELL_W-1:0] RESET_BLANK = {RESET_ATTR, CHAR_SPACE};

    typedef enum logic [COMMAND_W-1:0] {
        CMD_PUT   = 2'd0,
        CMD_ERASE = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_READ  = 2'd3
    } tcw_cmd_t;

    // decoded operation kinds
    typedef enum logic [3:0] {
        K_PRINT,
        K_BACK,
        K_TAB,
        K_RET,
        K_LINE,
        K_NOP,
        K_ERASE,
        K_CLEAR,
        K_READ
    } tcw_kind_t;

    // one decoded request as it sits in the queue
    typedef struct packed {
        tcw_kind_t           kind;
        logic [CHAR_W-1:0]   code;
        logic [INDEX_W-1:0]  index;
        logic                hit;
    } tcw_op_t;

endpackage

/* design/tcw_front.sv */
module tcw_front import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [COMMAND_W-1:0] s_command,
    input  logic [CHAR_W-1:0]  s_char_code,
    input  logic [INDEX_W-1:0] s_cell_index,
    input  logic               back_ready,
    input  logic               queue_full,
    output logic               push,
    output tcw_op_t            push_op
);

    localparam int CELLS = COLUMNS * ROWS;

    tcw_cmd_t  cmd;
    tcw_kind_t kind;

    assign cmd = tcw_cmd_t'(s_command);

    // classify the request
    always_comb begin
        kind = K_NOP;
        unique case (cmd)
            CMD_PUT: begin
                if (s_char_code == CHAR_BS) begin
                    kind = K_BACK;
                end else if (s_char_code == CHAR_TAB) begin
                    kind = K_TAB;
                end else if (s_char_code == CHAR_CR) begin
                    kind = K_RET;
                end else if (s_char_code == CHAR_LF) begin
                    kind = K_LINE;
                end else if (s_char_code >= CHAR_SPACE && s_char_code <= CHAR_LAST) begin
                    kind = K_PRINT;
                end else begin
                    kind = K_NOP;
                end
            end
            CMD_ERASE: kind = K_ERASE;
            CMD_CLEAR: kind = K_CLEAR;
            CMD_READ:  kind = K_READ;
            default:   kind = K_NOP;
        endcase
    end

    // queue entry
    always_comb begin
        push_op.kind  = kind;
        push_op.code  = s_char_code;
        push_op.index = s_cell_index;
        push_op.hit   = (32'(s_cell_index) < 32'(CELLS));
    end

    // take requests only once the framebuffer is initialized and there is room
    assign s_ready = back_ready && !queue_full;
    assign push    = s_valid && s_ready;

endmodule

/* design/tcw_queue.sv */
module tcw_queue import tcw_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  tcw_op_t push_op,
    output logic    full,
    input  logic    pop,
    output logic    op_valid,
    output tcw_op_t op
);

    // two-entry queue between decode and execute
    tcw_op_t    slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign op_valid = (count_reg != 2'd0);
    assign op       = slot_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

/* design/tcw_back.sv */
module tcw_back import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [ATTR_W-1:0] cfg_wr_data,
    input  logic              op_valid,
    input  tcw_op_t           op,
    output logic              op_pop,
    output logic              back_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [LOC_W-1:0]  m_cursor_location,
    output logic [CELL_W-1:0] m_cell_value
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);

    localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] SECOND_ROW  = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] BOTTOM_ROW  = ADDR_W'(CELLS - COLUMNS);
    localparam logic [COL_W:0]    TAB_ADD     = (COL_W + 1)'(TAB_STOP);
    localparam logic [COL_W:0]    TAB_MASK    = ~((COL_W + 1)'(TAB_STOP - 1));
    localparam logic [COL_W:0]    COL_LIMIT   = (COL_W + 1)'(COLUMNS);
    localparam logic [ROW_W:0]    ROW_LIMIT   = (ROW_W + 1)'(ROWS);
    localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(ROWS - 1);

    typedef enum logic [6:0] {
        ST_INIT  = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_CLEAR = 7'b0000100,
        ST_SCROLL = 7'b0001000,
        ST_FLUSH = 7'b0010000,
        ST_FILL  = 7'b0100000,
        ST_DONE  = 7'b1000000
    } tcw_state_t;

    tcw_state_t         state_reg, state_next;
    logic [ADDR_W-1:0]  ptr_reg, ptr_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic               pend_reg, pend_next;
    logic [ADDR_W-1:0]  pend_addr_reg, pend_addr_next;
    logic               hit_reg, hit_next;
    logic [ATTR_W-1:0]  attr_reg;
    logic               m_valid_reg, m_valid_next;
    logic [LOC_W-1:0]   m_loc_reg, m_loc_next;
    logic [CELL_W-1:0]  m_value_reg, m_value_next;

    logic [CELL_W-1:0]  screen_mem [CELLS];
    logic [CELL_W-1:0]  rd_data_reg;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [CELL_W-1:0]  mem_wdata;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_raddr;

    logic [COL_W:0]     col_ext, ncol;
    logic [ROW_W:0]     row_ext, nrow;
    logic               line_inc, wrap, scroll;
    logic [COL_W-1:0]   ncol_fin;
    logic [ROW_W-1:0]   nrow_fin;
    logic [ADDR_W-1:0]  cur_addr;
    logic [CELL_W-1:0]  blank;
    logic [ADDR_W+LOC_W-1:0]   loc_wide;
    logic [ADDR_W+INDEX_W-1:0] idx_wide;

    assign blank    = {attr_reg, CHAR_SPACE};
    assign cur_addr = ADDR_W'(row_reg) * SECOND_ROW + ADDR_W'(col_reg);
    assign loc_wide = (ADDR_W + LOC_W)'(cur_addr);
    assign idx_wide = (ADDR_W + INDEX_W)'(op.index);

    assign back_ready        = (state_reg != ST_INIT);
    assign m_valid           = m_valid_reg;
    assign m_cursor_location = m_loc_reg;
    assign m_cell_value      = m_value_reg;

    // cursor movement for the request at the queue head
    always_comb begin
        col_ext  = {1'b0, col_reg};
        row_ext  = {1'b0, row_reg};
        ncol     = col_ext;
        line_inc = 1'b0;
        unique case (op.kind)
            K_PRINT: ncol = col_ext + (COL_W + 1)'(1);
            K_BACK, K_ERASE: begin
                if (col_reg != '0) begin
                    ncol = col_ext - (COL_W + 1)'(1);
                end
            end
            K_TAB: ncol = (col_ext + TAB_ADD) & TAB_MASK;
            K_RET: ncol = '0;
            K_LINE: begin
                ncol     = '0;
                line_inc = 1'b1;
            end
            default: ncol = col_ext;
        endcase
        wrap     = (ncol >= COL_LIMIT);
        nrow     = row_ext + (ROW_W + 1)'(line_inc | wrap);
        scroll   = (nrow >= ROW_LIMIT);
        ncol_fin = wrap ? '0 : ncol[COL_W-1:0];
        nrow_fin = scroll ? LAST_ROW : nrow[ROW_W-1:0];
    end

    // execute sequencer
    always_comb begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        hit_next       = hit_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_loc_next     = m_loc_reg;
        m_value_next   = m_value_reg;
        op_pop         = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = ptr_reg;
        mem_wdata      = blank;
        mem_re         = 1'b0;
        mem_raddr      = ptr_reg;

        unique case (state_reg)
            // blank every cell after reset
            ST_INIT: begin
                mem_we    = 1'b1;
                mem_wdata = RESET_BLANK;
                if (ptr_reg == LAST_CELL) begin
                    ptr_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    ptr_next = ptr_reg + ADDR_W'(1);
                end
            end
            // take the next request once the result register frees up
            ST_IDLE: begin
                if (op_valid && (!m_valid_reg || m_ready)) begin
                    op_pop   = 1'b1;
                    hit_next = 1'b0;
                    unique case (op.kind)
                        K_CLEAR: begin
                            col_next   = '0;
                            row_next   = '0;
                            ptr_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        K_READ: begin
                            hit_next   = op.hit;
                            mem_re     = op.hit;
                            mem_raddr  = idx_wide[ADDR_W-1:0];
                            state_next = ST_DONE;
                        end
                        default: begin
                            col_next = ncol_fin;
                            row_next = nrow_fin;
                            if (op.kind == K_PRINT) begin
                                mem_we    = 1'b1;
                                mem_waddr = cur_addr;
                                mem_wdata = {attr_reg, op.code};
                            end else if (op.kind == K_ERASE && col_reg != '0) begin
                                mem_we    = 1'b1;
                                mem_waddr = cur_addr - ADDR_W'(1);
                            end
                            ptr_next   = SECOND_ROW;
                            pend_next  = 1'b0;
                            state_next = scroll ? ST_SCROLL : ST_DONE;
                        end
                    endcase
                end
            end
            // blank the whole screen
            ST_CLEAR: begin
                mem_we = 1'b1;
                if (ptr_reg == LAST_CELL) begin
                    state_next = ST_DONE;
                end else begin
                    ptr_next = ptr_reg + ADDR_W'(1);
                end
            end
            // move each row up: read one cell, write the previous read one row up
            ST_SCROLL: begin
                mem_re         = 1'b1;
                mem_raddr      = ptr_reg;
                mem_we         = pend_reg;
                mem_waddr      = pend_addr_reg;
                mem_wdata      = rd_data_reg;
                pend_next      = 1'b1;
                pend_addr_next = ptr_reg - SECOND_ROW;
                if (ptr_reg == LAST_CELL) begin
                    state_next = ST_FLUSH;
                end else begin
                    ptr_next = ptr_reg + ADDR_W'(1);
                end
            end
            // last moved cell
            ST_FLUSH: begin
                mem_we     = 1'b1;
                mem_waddr  = pend_addr_reg;
                mem_wdata  = rd_data_reg;
                ptr_next   = BOTTOM_ROW;
                state_next = ST_FILL;
            end
            // blank the bottom row
            ST_FILL: begin
                mem_we = 1'b1;
                if (ptr_reg == LAST_CELL) begin
                    state_next = ST_DONE;
                end else begin
                    ptr_next = ptr_reg + ADDR_W'(1);
                end
            end
            // load the result register
            ST_DONE: begin
                m_valid_next = 1'b1;
                m_loc_next   = loc_wide[LOC_W-1:0];
                m_value_next = hit_reg ? rd_data_reg : '0;
                state_next   = ST_IDLE;
            end
            default: state_next = ST_INIT;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            ptr_reg     <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            pend_reg    <= 1'b0;
            hit_reg     <= 1'b0;
            attr_reg    <= RESET_ATTR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            pend_reg    <= pend_next;
            hit_reg     <= hit_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                attr_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        pend_addr_reg <= pend_addr_next;
        m_loc_reg     <= m_loc_next;
        m_value_reg   <= m_value_next;
    end

    // framebuffer, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= screen_mem[mem_raddr];
        end
    end

endmodule

/* design/text_console_writer.sv */
// channel   | handshake                | payload
// ----------+--------------------------+-----------------------------------------
// request   | s_valid / s_ready        | s_command, s_char_code, s_cell_index
// result    | m_valid / m_ready        | m_cursor_location, m_cell_value
// config    | cfg_wr_en (no wait)      | cfg_wr_data (text attribute)
//
// A plain request passes from the queue through the execute states ST_IDLE
// and ST_DONE into the result register; the next waits for ST_IDLE again.
// A scroll adds ST_SCROLL (row move, one read and one write per cell),
// ST_FLUSH and ST_FILL (the bottom row); a clear adds ST_CLEAR over all cells.
// After reset s_ready stays low while every cell is blanked.
// A 2-entry queue keeps taking requests while the result register waits.
`include "assert_macros.svh"

module text_console_writer import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [ATTR_W-1:0]  cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [COMMAND_W-1:0] s_command,
    input  logic [CHAR_W-1:0]  s_char_code,
    input  logic [INDEX_W-1:0] s_cell_index,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [LOC_W-1:0]   m_cursor_location,
    output logic [CELL_W-1:0]  m_cell_value
);

    localparam int CELLS = COLUMNS * ROWS;

    logic    back_ready;
    logic    queue_full;
    logic    push;
    tcw_op_t push_op;
    logic    op_valid;
    tcw_op_t op;
    logic    op_pop;

    // decode
    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_char_code  (s_char_code),
        .s_cell_index (s_cell_index),
        .back_ready   (back_ready),
        .queue_full   (queue_full),
        .push         (push),
        .push_op      (push_op)
    );

    // request queue
    tcw_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_op  (push_op),
        .full     (queue_full),
        .pop      (op_pop),
        .op_valid (op_valid),
        .op       (op)
    );

    // execute and framebuffer
    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .op_valid          (op_valid),
        .op                (op),
        .op_pop            (op_pop),
        .back_ready        (back_ready),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_cursor_location (m_cursor_location),
        .m_cell_value      (m_cell_value)
    );

    // checks
    `ASSERT_IMPLIES(a_pop_has_op, aclk, aresetn, op_pop, op_valid, "pop from empty queue")
    `ASSERT_IMPLIES(a_pop_out_free, aclk, aresetn, op_pop, !m_valid || m_ready, "pop while result blocked")
    `ASSERT_IMPLIES(a_cursor_range, aclk, aresetn, m_valid, (CELLS > 2047) || (32'(m_cursor_location) < 32'(CELLS)), "cursor off screen")
    `ASSERT_NEXT(a_push_lands, aclk, aresetn, push, op_valid, "accepted request missing from queue")

endmodule

/* tb/tb_text_console_writer.sv */
`default_nettype none

module tb_text_console_writer;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam int SCREEN_COLS  = 80;
    localparam int SCREEN_ROWS  = 25;
    localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;

    typedef struct {
        tcw_cmd_t            cmd;
        logic [CHAR_W-1:0]   code;
        logic [INDEX_W-1:0]  index;
    } console_req_t;

    typedef struct {
        logic [LOC_W-1:0]    loc;
        logic [CELL_W-1:0]   value;
    } console_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [ATTR_W-1:0]    cfg_wr_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [COMMAND_W-1:0] s_command = '0;
    logic [CHAR_W-1:0]    s_char_code = '0;
    logic [INDEX_W-1:0]   s_cell_index = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [LOC_W-1:0]     m_cursor_location;
    logic [CELL_W-1:0]    m_cell_value;

    // requests waiting for the driver and results waiting for the block
    console_req_t    pending_reqs[$];
    console_result_t results_due[$];
    int unsigned     reqs_made = 0;
    int unsigned     reqs_accepted = 0;
    int unsigned     error_count = 0;
    bit              idle_free = 1'b0;
    int              send_gap = 0;
    int              recv_gap = 0;

    // shadow of the screen, cursor and attribute
    logic [CELL_W-1:0] shadow_screen [SCREEN_CELLS];
    int unsigned       cur_col;
    int unsigned       cur_row;
    logic [ATTR_W-1:0] cur_attr;

    text_console_writer #(
        .COLUMNS (SCREEN_COLS),
        .ROWS    (SCREEN_ROWS)
    ) uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_char_code       (s_char_code),
        .s_cell_index      (s_cell_index),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_cursor_location (m_cursor_location),
        .m_cell_value      (m_cell_value)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("%0t: %s: got %h, expected %h", $time, what, got, want);
        error_count++;
    endtask

    function automatic void blank_cells(int from, int upto);
        for (int i = from; i < upto; i++) begin
            shadow_screen[i] = {cur_attr, CHAR_SPACE};
        end
    endfunction

    // apply one request to the shadow screen and give the result it yields
    function automatic console_result_t console_step(console_req_t req);
        console_result_t res;
        res.value = '0;
        case (req.cmd)
            CMD_PUT: begin
                if (req.code == CHAR_BS) begin
                    if (cur_col != 0) cur_col--;
                end else if (req.code == CHAR_TAB) begin
                    cur_col = (cur_col + TAB_STOP) & ~(TAB_STOP - 1);
                end else if (req.code == CHAR_CR) begin
                    cur_col = 0;
                end else if (req.code == CHAR_LF) begin
                    cur_col = 0;
                    cur_row++;
                end else if (req.code >= CHAR_SPACE && req.code <= CHAR_LAST) begin
                    shadow_screen[cur_row * SCREEN_COLS + cur_col] = {cur_attr, req.code};
                    cur_col++;
                end
                // wrap at line end, scroll past the last row
                if (cur_col >= SCREEN_COLS) begin
                    cur_col = 0;
                    cur_row++;
                end
                if (cur_row >= SCREEN_ROWS) begin
                    for (int i = 0; i < SCREEN_CELLS - SCREEN_COLS; i++) begin
                        shadow_screen[i] = shadow_screen[i + SCREEN_COLS];
                    end
                    blank_cells(SCREEN_CELLS - SCREEN_COLS, SCREEN_CELLS);
                    cur_row = SCREEN_ROWS - 1;
                end
            end
            CMD_ERASE: begin
                if (cur_col != 0) begin
                    cur_col--;
                    shadow_screen[cur_row * SCREEN_COLS + cur_col] = {cur_attr, CHAR_SPACE};
                end
            end
            CMD_CLEAR: begin
                blank_cells(0, SCREEN_CELLS);
                cur_col = 0;
                cur_row = 0;
            end
            default: begin
                if (req.index < SCREEN_CELLS) res.value = shadow_screen[req.index];
            end
        endcase
        res.loc = LOC_W'(cur_row * SCREEN_COLS + cur_col);
        return res;
    endfunction

    function automatic int draw_gap();
        return idle_free ? 0 : $urandom_range(0, 8);
    endfunction

    // request driver
    always @(posedge aclk) begin
        console_req_t req;
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap <= 0;
        end else if (!s_valid || s_ready) begin
            if (send_gap != 0) begin
                s_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_reqs.size() != 0) begin
                req = pending_reqs.pop_front();
                s_valid <= 1'b1;
                s_command <= req.cmd;
                s_char_code <= req.code;
                s_cell_index <= req.index;
                send_gap <= draw_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver with random stalls
    always @(posedge aclk) begin
        int stall;
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_gap <= 0;
        end else if (m_valid && m_ready) begin
            stall = draw_gap();
            m_ready <= (stall == 0);
            recv_gap <= stall;
        end else if (recv_gap != 0) begin
            recv_gap <= recv_gap - 1;
            m_ready <= (recv_gap == 1);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // monitor: predict on each accepted request, check each accepted result
    always @(posedge aclk) begin
        console_req_t    req;
        console_result_t want;
        if (!aresetn) begin
            cur_attr = RESET_ATTR;
            blank_cells(0, SCREEN_CELLS);
            cur_col = 0;
            cur_row = 0;
            results_due.delete();
        end else begin
            if (cfg_wr_en) cur_attr = cfg_wr_data;
            if (s_valid && s_ready) begin
                req.cmd = tcw_cmd_t'(s_command);
                req.code = s_char_code;
                req.index = s_cell_index;
                results_due.push_back(console_step(req));
                reqs_accepted++;
            end
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    report_mismatch("result with no request pending", m_cursor_location, 0);
                end else begin
                    want = results_due.pop_front();
                    if (m_cursor_location !== want.loc)
                        report_mismatch("cursor_location", m_cursor_location, want.loc);
                    if (m_cell_value !== want.value)
                        report_mismatch("cell_value", m_cell_value, want.value);
                end
            end
        end
    end

    task automatic queue_req(tcw_cmd_t cmd, logic [CHAR_W-1:0] code,
                             logic [INDEX_W-1:0] index);
        console_req_t req;
        while (pending_reqs.size() > 4) @(posedge aclk);
        req.cmd = cmd;
        req.code = code;
        req.index = index;
        pending_reqs.push_back(req);
        reqs_made++;
    endtask

    function automatic logic [INDEX_W-1:0] any_index();
        return INDEX_W'($urandom_range(0, 2047));
    endfunction

    // a cell on the cursor's row, as far as the generator knows it
    function automatic logic [INDEX_W-1:0] cursor_row_index();
        return INDEX_W'(cur_row * SCREEN_COLS + $urandom_range(0, SCREEN_COLS - 1));
    endfunction

    // a line of text with edits mixed in, usually ended by a newline
    task automatic make_text_run();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 30);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 19))
                0: queue_req(CMD_PUT, CHAR_BS, any_index());
                1: queue_req(CMD_PUT, CHAR_TAB, any_index());
                2: queue_req(CMD_ERASE, CHAR_W'($urandom), any_index());
                3: queue_req(CMD_READ, CHAR_W'($urandom), cursor_row_index());
                default: queue_req(CMD_PUT, CHAR_W'($urandom_range(CHAR_SPACE, CHAR_LAST)),
                                   any_index());
            endcase
        end
        case ($urandom_range(0, 3))
            0, 1: queue_req(CMD_PUT, CHAR_LF, any_index());
            2: begin
                queue_req(CMD_PUT, CHAR_CR, any_index());
                queue_req(CMD_PUT, CHAR_LF, any_index());
            end
            default: ;
        endcase
    endtask

    // reads of written text, random cells and out of range cells
    task automatic make_readback();
        int n;
        int pick;
        logic [INDEX_W-1:0] idx;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) idx = cursor_row_index();
            else if (pick < 6 && cur_row > 0)
                idx = INDEX_W'(cursor_row_index() - SCREEN_COLS);
            else if (pick < 8) idx = INDEX_W'($urandom_range(0, SCREEN_CELLS - 1));
            else if (pick < 9)
                idx = INDEX_W'($urandom_range(SCREEN_CELLS - 2 * SCREEN_COLS, SCREEN_CELLS - 1));
            else idx = INDEX_W'($urandom_range(SCREEN_CELLS, 2047));
            queue_req(CMD_READ, CHAR_W'($urandom), idx);
        end
    endtask

    // any command with any fields, clears kept rare
    task automatic make_noise();
        int n;
        tcw_cmd_t cmd;
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) begin
            cmd = tcw_cmd_t'($urandom_range(0, 3));
            if (cmd == CMD_CLEAR && $urandom_range(0, 9) != 0) cmd = CMD_READ;
            queue_req(cmd, CHAR_W'($urandom), any_index());
        end
    endtask

    task automatic wait_idle();
        while (reqs_accepted != reqs_made || results_due.size() != 0) @(posedge aclk);
    endtask

    task automatic write_attr(logic [ATTR_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // stimulus
    initial begin
        int unsigned phase_end;
        logic [ATTR_W-1:0] attr_pick;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        do @(posedge aclk); while (!s_ready);

        // directed: reset contents, range ends, every control code, erase at column zero
        queue_req(CMD_READ, 8'h00, 11'd0);
        queue_req(CMD_READ, 8'hFF, 11'd1999);
        queue_req(CMD_READ, 8'h5A, 11'd2000);
        queue_req(CMD_READ, 8'hA5, 11'd2047);
        queue_req(CMD_PUT, 8'h41, 11'h7FF);
        queue_req(CMD_PUT, CHAR_SPACE, 11'd0);
        queue_req(CMD_PUT, CHAR_LAST, 11'd0);
        queue_req(CMD_PUT, 8'h00, 11'd0);
        queue_req(CMD_PUT, 8'h1F, 11'd0);
        queue_req(CMD_PUT, 8'h80, 11'd0);
        queue_req(CMD_PUT, 8'hFF, 11'd0);
        queue_req(CMD_PUT, CHAR_BS, 11'd0);
        queue_req(CMD_ERASE, 8'hFF, 11'h7FF);
        queue_req(CMD_PUT, CHAR_TAB, 11'd0);
        queue_req(CMD_PUT, CHAR_CR, 11'd0);
        queue_req(CMD_ERASE, 8'h00, 11'd0);
        queue_req(CMD_PUT, CHAR_BS, 11'd0);
        queue_req(CMD_PUT, CHAR_LF, 11'd0);
        queue_req(CMD_READ, 8'h00, 11'd0);
        queue_req(CMD_READ, 8'h00, 11'd1);
        queue_req(CMD_CLEAR, 8'hFF, 11'h7FF);
        queue_req(CMD_READ, 8'h00, 11'd0);

        // random phases, each under its own attribute, written while idle
        phase_end = reqs_made;
        for (int phase = 0; phase < 5; phase++) begin
            wait_idle();
            case (phase)
                0: attr_pick = 8'h00;
                1: attr_pick = 8'hFF;
                4: attr_pick = RESET_ATTR;
                default: attr_pick = ATTR_W'($urandom);
            endcase
            write_attr(attr_pick);
            phase_end += 366;
            while (reqs_made < phase_end) begin
                idle_free = ($urandom_range(0, 5) == 0);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: make_text_run();
                    5, 6, 7: make_readback();
                    default: make_noise();
                endcase
            end
        end

        wait_idle();
        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // run limit, well above a run where every request scrolls under the longest stalls
    initial begin
        #200000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
